// ===== src/binary_to_decimal_ascii_macros.svh =====
// Assertion macros shared by the converter modules.
`ifndef BINARY_TO_DECIMAL_ASCII_MACROS_SVH
`define BINARY_TO_DECIMAL_ASCII_MACROS_SVH

`ifndef NO_ASSERTIONS

`define B2DA_ASSERT_IMP(label, pre, post) \
  label: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
    else $error("b2da assertion failed");

`define B2DA_ASSERT_NXT(label, pre, post) \
  label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
    else $error("b2da assertion failed");

`else

`define B2DA_ASSERT_IMP(label, pre, post)

`define B2DA_ASSERT_NXT(label, pre, post)

`endif

`endif

// ===== src/b2da_pkg.sv =====
// Shared constants and types of the binary to decimal ASCII converter.
`default_nettype none

package b2da_pkg;

  localparam int VALUE_W    = 64;
  localparam int NUM_DIGITS = 19;
  localparam int BCD_W      = 4 * NUM_DIGITS;
  localparam int SHIFT_CW   = $clog2(VALUE_W);
  localparam int LEFT_W     = $clog2(NUM_DIGITS + 1);
  localparam int CHAR_W     = 6;

  localparam logic [CHAR_W-1:0] ASCII_ZERO = 6'd48;

  // Packed BCD result handed from the shifter to the emitter.
  typedef struct packed {
    logic             valid;
    logic [BCD_W-1:0] bcd;
  } bcd_res_t;

endpackage

`default_nettype wire

// ===== src/b2da_dabble.sv =====
// Bit-serial double-dabble shifter: magnitude in, packed BCD out.
`default_nettype none

`include "binary_to_decimal_ascii_macros.svh"

module b2da_dabble (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            in_valid,
  output logic                                 in_ready,
  input  wire logic signed [b2da_pkg::VALUE_W-1:0] value,
  output b2da_pkg::bcd_res_t                   res,
  input  wire logic                            res_ready
);
  import b2da_pkg::*;

  typedef enum logic [1:0] {
    IDLE,
    SHIFT,
    DONE
  } state_t;

  state_t              state;
  logic [VALUE_W-1:0]  mag;
  logic [BCD_W-1:0]    bcd;
  logic [SHIFT_CW-1:0] cnt;
  logic [BCD_W-1:0]    bcd_adj;

  // add 3 to every digit of 5 or more before the shift
  always_comb begin
    for (int i = 0; i < NUM_DIGITS; i++) begin
      if (bcd[4*i +: 4] >= 4'd5) begin
        bcd_adj[4*i +: 4] = bcd[4*i +: 4] + 4'd3;
      end else begin
        bcd_adj[4*i +: 4] = bcd[4*i +: 4];
      end
    end
  end

  assign in_ready  = (state == IDLE);
  assign res.valid = (state == DONE);
  assign res.bcd   = bcd;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= IDLE;
      cnt   <= '0;
    end else begin
      case (state)
        IDLE: begin
          if (in_valid) begin
            // unsigned negate keeps the most negative value exact
            mag   <= value[VALUE_W-1] ? (VALUE_W'(0) - $unsigned(value)) : $unsigned(value);
            bcd   <= '0;
            cnt   <= '0;
            state <= SHIFT;
          end
        end
        SHIFT: begin
          bcd <= {bcd_adj[BCD_W-2:0], mag[VALUE_W-1]};
          mag <= {mag[VALUE_W-2:0], 1'b0};
          cnt <= cnt + 1'b1;
          if (cnt == SHIFT_CW'(VALUE_W - 1)) begin
            state <= DONE;
          end
        end
        DONE: begin
          if (res_ready) begin
            state <= IDLE;
          end
        end
        default: state <= IDLE;
      endcase
    end
  end

  `B2DA_ASSERT_NXT(a_start_shift, in_valid && in_ready, state == SHIFT && cnt == '0)
  `B2DA_ASSERT_NXT(a_shift_end, state == SHIFT && cnt == SHIFT_CW'(VALUE_W - 1), state == DONE)
  `B2DA_ASSERT_IMP(a_top_digit, res.valid, bcd[BCD_W-1 -: 4] <= 4'd9)

endmodule

`default_nettype wire

// ===== src/b2da_emit.sv =====
// Digit emitter: drops leading zeros, sends one ASCII digit per transaction.
`default_nettype none

`include "binary_to_decimal_ascii_macros.svh"

module b2da_emit (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire b2da_pkg::bcd_res_t            res,
  output logic                               res_ready,
  output logic                               out_valid,
  input  wire logic                          out_ready,
  output logic [b2da_pkg::CHAR_W-1:0]        digit_char,
  output logic                               last_digit
);
  import b2da_pkg::*;

  typedef enum logic [1:0] {
    IDLE,
    SKIP,
    EMIT
  } state_t;

  state_t            state;
  logic [BCD_W-1:0]  digs;
  logic [LEFT_W-1:0] left;
  logic [3:0]        top;

  assign top        = digs[BCD_W-1 -: 4];
  assign res_ready  = (state == IDLE);
  assign out_valid  = (state == EMIT);
  assign digit_char = ASCII_ZERO | {2'b00, top};
  assign last_digit = (left == LEFT_W'(1));

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= IDLE;
      left  <= '0;
    end else begin
      case (state)
        IDLE: begin
          if (res.valid) begin
            digs  <= res.bcd;
            left  <= LEFT_W'(NUM_DIGITS);
            state <= SKIP;
          end
        end
        SKIP: begin
          if (left == '0) begin
            state <= IDLE;  // zero input: nothing to send
          end else if (top == 4'd0) begin
            digs <= {digs[BCD_W-5:0], 4'd0};
            left <= left - 1'b1;
          end else begin
            state <= EMIT;
          end
        end
        EMIT: begin
          if (out_ready) begin
            digs <= {digs[BCD_W-5:0], 4'd0};
            left <= left - 1'b1;
            if (left == LEFT_W'(1)) begin
              state <= IDLE;
            end
          end
        end
        default: state <= IDLE;
      endcase
    end
  end

  `B2DA_ASSERT_IMP(a_digit_range, out_valid, top <= 4'd9)
  `B2DA_ASSERT_IMP(a_left_nonzero, out_valid, left != '0)
  `B2DA_ASSERT_NXT(a_last_ends, out_valid && out_ready && last_digit, !out_valid)
  `B2DA_ASSERT_NXT(a_load_skip, res.valid && res_ready, state == SKIP)

endmodule

`default_nettype wire

// ===== src/binary_to_decimal_ascii.sv =====
// Top level of the binary to decimal ASCII converter.
// Input channel (in_valid/in_ready/value) takes one signed 64-bit integer per
// transaction. Output channel (out_valid/out_ready/digit_char/last_digit)
// returns the decimal digits of its magnitude as ASCII, most significant
// first, no sign, no leading zeros; last_digit flags the final digit.
// A zero input produces no output transactions at all.
// The double-dabble shifter shifts in every input bit, then hands its BCD
// result to the emitter, which skips the leading zeros one at a time and
// moves on when it sees the first nonzero digit. Digits then go out one per
// cycle while out_ready is high. The shifter accepts a new value only after
// its last result is handed off, for any digit count; the emitter's work
// overlaps the next value's shift loop, so while out_ready stays high it is idle again at the next handoff.
// When out_ready is low the current digit holds and the emitter waits; a
// finished BCD result then waits in the shifter, and in_ready stays low.
// Reset (rst, synchronous, active high) returns both stages to idle and
// drops any value in progress.
`default_nettype none

module binary_to_decimal_ascii (
  input  wire logic                                clk,
  input  wire logic                                rst,
  input  wire logic                                in_valid,
  output logic                                     in_ready,
  input  wire logic signed [b2da_pkg::VALUE_W-1:0] value,
  output logic                                     out_valid,
  input  wire logic                                out_ready,
  output logic [b2da_pkg::CHAR_W-1:0]              digit_char,
  output logic                                     last_digit
);
  import b2da_pkg::*;

  bcd_res_t res;
  logic     res_ready;

  b2da_dabble u_dabble (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .value     (value),
    .res       (res),
    .res_ready (res_ready)
  );

  b2da_emit u_emit (
    .clk        (clk),
    .rst        (rst),
    .res        (res),
    .res_ready  (res_ready),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .digit_char (digit_char),
    .last_digit (last_digit)
  );

endmodule

`default_nettype wire
